// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("check failed: cond");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: ante implies cons");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/rrf_pkg.sv -----
// types and constants of the rounded rectangle fill rasteriser
// no dependencies; used by every module of the block
package rrf_pkg;

  localparam int MAX_DIMENSION_DEF = 4096;
  localparam int QDEPTH            = 2;
  localparam int QPTR_W            = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W            = $clog2(QDEPTH + 1);

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 2'd2;

  // one scanned pixel, already classified
  typedef struct packed {
    logic               idle;
    logic               fin;
    logic               corner;
    logic signed [7:0]  dx;
    logic signed [7:0]  dy;
    logic [13:0]        rr;
    logic signed [14:0] px;
    logic signed [14:0] py;
    logic [31:0]        color;
  } desc_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

// ----- rtl/rrf_queue.sv -----
// short descriptor queue between front and back
// depends on rrf_pkg
module rrf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rrf_pkg::desc_t  wdata,
  input  logic            pop,
  output rrf_pkg::desc_t  rdata,
  output rrf_pkg::q_stat_t stat
);
  import rrf_pkg::*;

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

// ----- rtl/rrf_front.sv -----
// front end: takes start and step beats, keeps the scan position,
// classifies each scanned pixel into a descriptor; depends on rrf_pkg
module rrf_front #(
  parameter int MAX_DIMENSION = rrf_pkg::MAX_DIMENSION_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rrf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  rrf_pkg::q_stat_t                q_stat,
  output logic                            q_push,
  output rrf_pkg::desc_t                  q_wdata
);
  import rrf_pkg::*;

  localparam int SAT   = (MAX_DIMENSION > 8191) ? 8191 : MAX_DIMENSION;
  localparam int DIM_W = $clog2(SAT + 1);
  localparam int COL_W = $clog2(SAT);
  localparam int CW    = ((DIM_W > 7) ? DIM_W : 7) + 2;

  logic                    busy_r, busy_nxt;
  logic [COL_W-1:0]        col_r, col_nxt;
  logic [COL_W-1:0]        row_r, row_nxt;
  logic signed [12:0]      org_x_r, org_y_r;
  logic [DIM_W-1:0]        wid_r, hgt_r;
  logic [6:0]              rad_r;
  logic [13:0]             rr_r;
  logic signed [CW-1:0]    wr_r, hr_r;
  logic [31:0]             color_r;

  logic                    accept;
  logic signed [12:0]      f_org_x, f_org_y;
  logic [12:0]             f_wid, f_hgt;
  logic [7:0]              f_rad;
  logic [31:0]             f_color;
  logic [DIM_W-1:0]        wid_sat, hgt_sat;
  logic [6:0]              rad_clamp;
  logic signed [CW-1:0]    r_ext, ic, jc;
  logic [COL_W:0]          col_inc, row_inc;
  logic                    col_last, row_last, fin;
  logic                    left, right, top, bot;
  logic signed [CW-1:0]    dx_full, dy_full;

  assign f_org_x = in_tdata[12:0];
  assign f_org_y = in_tdata[25:13];
  assign f_wid   = in_tdata[38:26];
  assign f_hgt   = in_tdata[51:39];
  assign f_rad   = in_tdata[59:52];
  assign f_color = in_tdata[91:60];

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  assign wid_sat   = (f_wid > 13'(SAT)) ? DIM_W'(SAT) : f_wid[DIM_W-1:0];
  assign hgt_sat   = (f_hgt > 13'(SAT)) ? DIM_W'(SAT) : f_hgt[DIM_W-1:0];
  assign rad_clamp = f_rad[7] ? 7'd0 : f_rad[6:0];

  // scan position tests
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign col_last = col_inc >= (COL_W+1)'(wid_r);
  assign row_last = row_inc >= (COL_W+1)'(hgt_r);
  assign fin      = col_last && row_last;

  // corner classification, left and top regions take priority
  assign r_ext   = $signed({{(CW-7){1'b0}}, rad_r});
  assign ic      = $signed({{(CW-COL_W){1'b0}}, col_r});
  assign jc      = $signed({{(CW-COL_W){1'b0}}, row_r});
  assign left    = ic < r_ext;
  assign right   = ic >= wr_r;
  assign top     = jc < r_ext;
  assign bot     = jc >= hr_r;
  assign dx_full = left ? (ic - r_ext) : (ic - wr_r);
  assign dy_full = top  ? (jc - r_ext) : (jc - hr_r);

  always_comb begin
    q_push         = accept && (in_tuser == OP_STEP);
    q_wdata.idle   = !busy_r;
    q_wdata.fin    = fin;
    q_wdata.corner = (left || right) && (top || bot);
    q_wdata.dx     = dx_full[7:0];
    q_wdata.dy     = dy_full[7:0];
    q_wdata.rr     = rr_r;
    q_wdata.px     = 15'(org_x_r) + $signed({{(15-COL_W){1'b0}}, col_r});
    q_wdata.py     = 15'(org_y_r) + $signed({{(15-COL_W){1'b0}}, row_r});
    q_wdata.color  = color_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (accept) begin
      if (in_tuser == OP_START) begin
        busy_nxt = (wid_sat != '0) && (hgt_sat != '0);
        col_nxt  = '0;
        row_nxt  = '0;
      end else if (busy_r) begin
        if (fin) begin
          busy_nxt = 1'b0;
          col_nxt  = '0;
          row_nxt  = '0;
        end else if (col_last) begin
          col_nxt = '0;
          row_nxt = row_inc[COL_W-1:0];
        end else begin
          col_nxt = col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_tuser == OP_START)) begin
      org_x_r <= f_org_x;
      org_y_r <= f_org_y;
      wid_r   <= wid_sat;
      hgt_r   <= hgt_sat;
      rad_r   <= rad_clamp;
      rr_r    <= 14'(rad_clamp * rad_clamp);
      wr_r    <= $signed({{(CW-DIM_W){1'b0}}, wid_sat}) -
                 $signed({{(CW-7){1'b0}}, rad_clamp});
      hr_r    <= $signed({{(CW-DIM_W){1'b0}}, hgt_sat}) -
                 $signed({{(CW-7){1'b0}}, rad_clamp});
      color_r <= f_color;
    end
  end

endmodule

// ----- rtl/rrf_back.sv -----
// back end: clip and circle test, address multiply, output register
// depends on rrf_pkg; holds the configuration registers
module rrf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  rrf_pkg::q_stat_t                 q_stat,
  input  rrf_pkg::desc_t                   q_rdata,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rrf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);
  import rrf_pkg::*;

  logic [12:0] scr_w_r, scr_h_r;
  logic [15:0] pitch_r;

  logic        s1_v_r;
  logic        s1_draw_r;
  logic        s1_last_r;
  logic [26:0] s1_prod_r;
  logic [12:0] s1_px_r;
  logic [31:0] s1_color_r;

  logic        o_v_r;
  logic        o_we_r;
  logic        o_last_r;
  logic [25:0] o_addr_r;
  logic [31:0] o_value_r;

  logic        adv1, adv2;
  logic        in_x, in_y, in_circle, draw;
  logic [15:0] sq_x, sq_y;
  logic [16:0] sq_sum;
  logic [26:0] addr_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= 13'd1024;
      scr_h_r <= 13'd768;
      pitch_r <= 16'd4096;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata[12:0];
        CFG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata[12:0];
        CFG_LINE_PITCH:    pitch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv2  = !o_v_r || out_tready;
  assign adv1  = !s1_v_r || adv2;
  assign q_pop = adv1 && !q_stat.empty;

  assign in_x      = !q_rdata.px[14] && (q_rdata.px[13:0] < {1'b0, scr_w_r});
  assign in_y      = !q_rdata.py[14] && (q_rdata.py[13:0] < {1'b0, scr_h_r});
  assign sq_x      = 16'(q_rdata.dx * q_rdata.dx);
  assign sq_y      = 16'(q_rdata.dy * q_rdata.dy);
  assign sq_sum    = {1'b0, sq_x} + {1'b0, sq_y};
  assign in_circle = !q_rdata.corner || (sq_sum <= {3'b000, q_rdata.rr});
  assign draw      = !q_rdata.idle && in_x && in_y && in_circle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_draw_r  <= draw;
      s1_last_r  <= q_rdata.idle || q_rdata.fin;
      s1_prod_r  <= q_rdata.py[12:0] * pitch_r[15:2];
      s1_px_r    <= q_rdata.px[12:0];
      s1_color_r <= q_rdata.color;
    end
  end

  assign addr_sum = s1_prod_r + {14'd0, s1_px_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv2) begin
      o_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      o_we_r    <= s1_draw_r;
      o_last_r  <= s1_last_r;
      o_addr_r  <= s1_draw_r ? addr_sum[25:0] : 26'd0;
      o_value_r <= s1_draw_r ? s1_color_r : 32'd0;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_we_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {6'd0, o_value_r, o_addr_r};

endmodule

// ----- rtl/rounded_rect_fill_raster.sv -----
// rounded rectangle fill rasteriser, top level
// a step beat goes through the queue and the back registers; one beat per cycle in steady
// flow, set by the front scan counters and the 2-stage back (circle test, stride multiply)
// start beats give no result; a full output with tready low stalls the back, the queue
// absorbs two steps before tready drops; reset (sync, active low) empties the pipe, idles
// the scan and restores screen 1024x768, pitch 4096; depends on rrf_pkg and the submodules
`include "assert_macros.svh"
module rounded_rect_fill_raster #(
  parameter int MAX_DIMENSION = rrf_pkg::MAX_DIMENSION_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rrf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // origin_x, origin_y, rect_width, rect_height, corner_radius, fill_color, zero pad
  input  logic [rrf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pixel_address, pixel_value, zero pad
  output logic [rrf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // write_enable
  output logic                             out_tuser,
  // last
  output logic                             out_tlast
);
  import rrf_pkg::*;

  q_stat_t q_stat;
  desc_t   q_wdata, q_rdata;
  logic    q_push, q_pop;

  rrf_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rrf_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  rrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  `ASSERT_ALWAYS(a_q_bound, clk, rst_n, q_stat.count <= QCNT_W'(QDEPTH))
  `ASSERT_IMPLIES(a_no_push_full, clk, rst_n, q_push, !q_stat.full || q_pop)
  `ASSERT_IMPLIES(a_skip_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0)

endmodule

// ----- tb/sv/tb_rounded_rect_fill_raster.sv -----
// testbench for rounded_rect_fill_raster: fill and step beats with bursty input and stalled output,
// every pixel beat checked against a scan model kept here; depends on rrf_pkg and the rtl
`timescale 1ns / 100ps
module tb_rounded_rect_fill_raster;
  import rrf_pkg::*;

  localparam int MAX_DIM = MAX_DIMENSION_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic                  op;
    logic [IN_TDATA_W-1:0] data;
  } beat_t;

  typedef struct packed {
    logic        we;
    logic [25:0] addr;
    logic [31:0] val;
    logic        last;
  } pix_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  rounded_rect_fill_raster dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  beat_t beat_q[$];
  pix_t  pix_expect_q[$];
  pix_t  got_exp;
  int    mism_cnt = 0;
  logic  in_took = 1'b0;

  // scan model state
  int scr_w = 1024;
  int scr_h = 768;
  int pitch = 4096;
  bit sc_busy = 0;
  int sc_col = 0;
  int sc_row = 0;
  int hold_ox = 0;
  int hold_oy = 0;
  int hold_w = 0;
  int hold_h = 0;
  int hold_r = 0;
  logic [31:0] hold_color = '0;

  // sender and receiver pacing
  int burst_left = 1;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("rounded_rect_fill_raster test failed");
    $finish;
  end

  function automatic bit corner_keep(int i, int j);
    longint r, w, h, dx, dy;
    r = hold_r;
    w = hold_w;
    h = hold_h;
    if (i < r && j < r) begin
      dx = i - r; dy = j - r;
    end else if (i >= w - r && j < r) begin
      dx = i - (w - r); dy = j - r;
    end else if (i < r && j >= h - r) begin
      dx = i - r; dy = j - (h - r);
    end else if (i >= w - r && j >= h - r) begin
      dx = i - (w - r); dy = j - (h - r);
    end else begin
      return 1'b1;
    end
    return dx * dx + dy * dy <= r * r;
  endfunction

  task automatic raster_predict(input logic op, input logic [IN_TDATA_W-1:0] d);
    logic signed [12:0] sx, sy;
    logic signed [7:0]  rs;
    longint px, py, addr;
    bit draw, fin;
    pix_t e;
    if (op == OP_START) begin
      sx = d[12:0];
      sy = d[25:13];
      rs = d[59:52];
      hold_ox = sx;
      hold_oy = sy;
      hold_w = (d[38:26] > MAX_DIM) ? MAX_DIM : d[38:26];
      hold_h = (d[51:39] > MAX_DIM) ? MAX_DIM : d[51:39];
      hold_r = (rs < 0) ? 0 : rs;
      hold_color = d[91:60];
      sc_col = 0;
      sc_row = 0;
      sc_busy = hold_w != 0 && hold_h != 0;
    end else if (!sc_busy) begin
      e = '{we: 1'b0, addr: '0, val: '0, last: 1'b1};
      pix_expect_q.push_back(e);
    end else begin
      px = longint'(hold_ox) + sc_col;
      py = longint'(hold_oy) + sc_row;
      draw = px >= 0 && px < scr_w && py >= 0 && py < scr_h && corner_keep(sc_col, sc_row);
      fin = (sc_col + 1 >= hold_w) && (sc_row + 1 >= hold_h);
      addr = py * (pitch / 4) + px;
      e.we = draw;
      e.addr = draw ? addr[25:0] : '0;
      e.val = draw ? hold_color : '0;
      e.last = fin;
      pix_expect_q.push_back(e);
      if (fin) begin
        sc_busy = 0;
        sc_col = 0;
        sc_row = 0;
      end else if (sc_col + 1 >= hold_w) begin
        sc_col = 0;
        sc_row++;
      end else begin
        sc_col++;
      end
    end
  endtask

  // acceptance, prediction and result check
  always @(posedge clk) begin
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pix_expect_q.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("unexpected pixel beat: we %0b addr %0h val %0h last %0b",
                     out_tuser, out_tdata[25:0], out_tdata[57:26], out_tlast);
        end else begin
          got_exp = pix_expect_q.pop_front();
          if (out_tuser !== got_exp.we || out_tdata[25:0] !== got_exp.addr ||
              out_tdata[57:26] !== got_exp.val || out_tlast !== got_exp.last) begin
            mism_cnt++;
            if (mism_cnt <= 10)
              $display("pixel mismatch: exp we %0b addr %0h val %0h last %0b, got %0b %0h %0h %0b",
                       got_exp.we, got_exp.addr, got_exp.val, got_exp.last,
                       out_tuser, out_tdata[25:0], out_tdata[57:26], out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready)
        raster_predict(in_tuser, in_tdata);
    end
  end

  // input driver: bursts with gaps
  always @(negedge clk) begin
    beat_t b;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (beat_q.size() > 0) begin
        b = beat_q.pop_front();
        in_tuser <= b.op;
        in_tdata <= b.data;
        in_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(64, 256);
    end
    rx_left--;
    rx_cnt++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= (rx_cnt % 5) != 0;
      default: out_tready <= $urandom_range(0, 7) == 0;
    endcase
  end

  task automatic push_fill(input logic [12:0] ox, input logic [12:0] oy, input logic [12:0] w,
                           input logic [12:0] h, input logic [7:0] r, input logic [31:0] c);
    beat_t b;
    b.op = OP_START;
    b.data = {4'b0, c, r, h, w, oy, ox};
    beat_q.push_back(b);
  endtask

  task automatic push_steps(input int n);
    beat_t b;
    repeat (n) begin
      b.op = OP_STEP;
      b.data = {4'b0, 28'($urandom), 32'($urandom), 32'($urandom)};
      beat_q.push_back(b);
    end
  endtask

  function automatic logic [12:0] pick_org(int lim);
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 8191);
      1, 2, 3: v = int'($urandom_range(0, 12)) - 6;
      4, 5, 6: v = lim - int'($urandom_range(0, 10));
      default: v = $urandom_range(0, (lim > 0) ? lim : 1);
    endcase
    return v[12:0];
  endfunction

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return 13'($urandom_range(4097, 8191));
      2: return 13'($urandom_range(9, 40));
      default: return 13'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic gen_phase(input int target);
    int cnt, ew, eh, total, n, kind;
    logic [12:0] w, h;
    logic [7:0] r;
    cnt = 0;
    while (cnt < target) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        n = $urandom_range(1, 3);
        push_steps(n);
        cnt += n;
      end else begin
        w = pick_dim();
        h = pick_dim();
        r = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
        ew = (w > MAX_DIM) ? MAX_DIM : w;
        eh = (h > MAX_DIM) ? MAX_DIM : h;
        total = ew * eh;
        push_fill(pick_org(scr_w), pick_org(scr_h), w, h, r, $urandom);
        if (kind == 1 || total > 300)
          n = $urandom_range(0, (total > 30) ? 30 : total);
        else
          n = total + $urandom_range(0, 1);
        push_steps(n);
        cnt += n + 1;
      end
    end
    // zero size fill leaves the scan idle for the next register writes
    push_fill('0, '0, '0, '0, '0, '0);
  endtask

  task automatic wait_drain();
    do @(posedge clk);
    while (beat_q.size() != 0 || in_tvalid || pix_expect_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SCREEN_WIDTH:  scr_w = val[12:0];
      CFG_SCREEN_HEIGHT: scr_h = val[12:0];
      CFG_LINE_PITCH:    pitch = val;
      default: ;
    endcase
  endtask

  task automatic set_screen(input logic [15:0] sw, input logic [15:0] sh, input logic [15:0] lp);
    wait_drain();
    write_reg(CFG_SCREEN_WIDTH, sw);
    write_reg(CFG_SCREEN_HEIGHT, sh);
    write_reg(CFG_LINE_PITCH, lp);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle step, empty sizes, clipping, oversize, restart, overlapping corners
    push_steps(1);
    push_fill(13'd0, 13'd0, 13'd0, 13'd5, 8'd3, 32'h1234_5678);
    push_steps(1);
    push_fill(13'd5, 13'd5, 13'd5, 13'd0, 8'd0, 32'h8765_4321);
    push_steps(1);
    push_fill(13'd1022, 13'h1FFF, 13'd3, 13'd2, 8'h80, 32'hFFFF_FFFF);
    push_steps(6);
    push_fill(13'h1000, 13'd4095, 13'h1FFF, 13'd4096, 8'd1, 32'h0F0F_0F0F);
    push_steps(3);
    push_fill(13'd10, 13'd20, 13'd3, 13'd3, 8'h7F, 32'h0000_0000);
    push_steps(9);
    gen_phase(110);

    set_screen(16'd4096, 16'd4096, 16'hFFFF);
    write_reg(CFG_NONE, 16'($urandom));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gen_phase(145);

    set_screen(16'd0, 16'd0, 16'd0);
    gen_phase(100);

    set_screen(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)), 16'($urandom));
    gen_phase(145);

    set_screen(16'd17, 16'd9, 16'd3);
    gen_phase(145);

    set_screen(16'hE000 | 16'd40, 16'hA000 | 16'd30, 16'd400);
    gen_phase(145);

    set_screen(16'd1024, 16'd768, 16'd4096);
    gen_phase(60);

    wait_drain();
    repeat (16) @(posedge clk);
    if (mism_cnt == 0 && pix_expect_q.size() == 0) begin
      $display("rounded_rect_fill_raster test passed");
    end else begin
      $display("rounded_rect_fill_raster test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rrf_pkg.sv
rtl/rrf_queue.sv
rtl/rrf_front.sv
rtl/rrf_back.sv
rtl/rounded_rect_fill_raster.sv
tb/sv/tb_rounded_rect_fill_raster.sv
